// ----- hdl/pmf_pkg.sv -----
package pmf_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int FCOUNT_W   = 5;

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_POP     = 2'd1,
        OP_SET_X   = 2'd2,
        OP_SET_Y   = 2'd3
    } pmf_op_t;

    typedef struct packed {
        pmf_op_t            op;
        logic [7:0]         rx_byte;
        logic signed [15:0] set_value;
    } pmf_item_t;

    typedef struct packed {
        logic signed [15:0] x_position;
        logic signed [15:0] y_position;
        logic               packet_done;
        logic               packet_dropped;
        logic               pop_valid;
        logic [7:0]         popped_status;
        logic [7:0]         last_status;
        logic [FCOUNT_W-1:0] fifo_count;
    } pmf_result_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } pmf_fifo_cmd_t;

    typedef struct packed {
        logic             dropped;
        logic             popped;
        logic [7:0]       rdata;
        logic [CNT_W-1:0] count;
    } pmf_fifo_rsp_t;

    typedef struct packed {
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic               done;
        logic [7:0]         status;
    } pmf_dec_t;

endpackage

// ----- hdl/ps2_mouse_packet_fifo_unit.sv -----
// PS/2 wheel-mouse packet decoder. Each accepted word carries an op: a received
// byte, a pop of the oldest stored status byte, or a load of the X or Y
// position. Every fourth received byte completes a packet (status, X delta,
// Y delta, wheel): the signed X delta is added to X, the signed Y delta is
// subtracted from Y, both wrapping at 16 bits, and the status byte goes into a
// status FIFO of FIFO_DEPTH entries, or is dropped and flagged if it is full.
// Every word produces exactly one result word with the positions, flags and
// FIFO fill after it. One word is taken per clock cycle unless a result is held
// unread (result_ready low): it passes an input register, one pass of decode,
// position add and FIFO access, and lands in the result register. The FIFO keeps
// its head entry in a register ahead of time, so a pop is served within that same pass.
module ps2_mouse_packet_fifo_unit
    import pmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  pmf_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output pmf_result_t result
);

    logic          held_valid;
    pmf_item_t     held_item;
    logic          advance;
    pmf_dec_t      dec;
    pmf_fifo_cmd_t fifo_cmd;
    pmf_fifo_rsp_t fifo_rsp;
    logic          out_valid_reg;
    logic          out_valid_next;
    pmf_result_t   out_reg;
    pmf_result_t   out_next;
    logic [CNT_W+FCOUNT_W-1:0] count_ext;

    assign advance = held_valid && (!out_valid_reg || result_ready);

    pmf_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    pmf_decoder u_decoder (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (held_item),
        .dec   (dec)
    );

    assign fifo_cmd.push  = advance && dec.done;
    assign fifo_cmd.pop   = advance && (held_item.op == OP_POP);
    assign fifo_cmd.wdata = dec.status;

    pmf_status_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fifo_cmd),
        .rsp   (fifo_rsp)
    );

    assign count_ext = {{FCOUNT_W{1'b0}}, fifo_rsp.count};

    always_comb
    begin
        out_next.x_position     = dec.x_pos;
        out_next.y_position     = dec.y_pos;
        out_next.packet_done    = dec.done;
        out_next.packet_dropped = fifo_rsp.dropped;
        out_next.pop_valid      = fifo_rsp.popped;
        out_next.popped_status  = fifo_rsp.rdata;
        out_next.last_status    = dec.status;
        out_next.fifo_count     = count_ext[FCOUNT_W-1:0];
    end

    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- hdl/pmf_in_reg.sv -----
module pmf_in_reg
    import pmf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  pmf_item_t item,
    input  logic      advance,
    output logic      held_valid,
    output pmf_item_t held_item
);

    logic      valid_reg;
    logic      valid_next;
    pmf_item_t item_reg;

    assign item_ready = !valid_reg || advance;
    assign valid_next = item_ready ? item_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ----- hdl/pmf_decoder.sv -----
module pmf_decoder
    import pmf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  pmf_item_t item,
    output pmf_dec_t  dec
);

    logic [1:0]         byte_idx_reg;
    logic [1:0]         byte_idx_next;
    logic [7:0]         pkt_reg [3];
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic [7:0]         latch_reg;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic               last_byte;

    assign last_byte = (item.op == OP_RX_BYTE) && (byte_idx_reg == 2'd3);
    assign dx = {{8{pkt_reg[1][7]}}, pkt_reg[1]};
    assign dy = {{8{pkt_reg[2][7]}}, pkt_reg[2]};

    always_comb
    begin
        dec.x_pos  = x_reg;
        dec.y_pos  = y_reg;
        dec.done   = 1'b0;
        dec.status = latch_reg;
        byte_idx_next = byte_idx_reg;
        case (item.op)
            OP_RX_BYTE:
            begin
                byte_idx_next = byte_idx_reg + 2'd1;
                if (last_byte)
                begin
                    // The fourth (wheel) byte itself is not used.
                    dec.done   = 1'b1;
                    dec.status = pkt_reg[0];
                    dec.x_pos  = x_reg + dx;
                    dec.y_pos  = y_reg - dy;
                end
            end
            OP_SET_X: dec.x_pos = item.set_value;
            OP_SET_Y: dec.y_pos = item.set_value;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg <= 2'd0;
            pkt_reg[0]   <= 8'd0;
            pkt_reg[1]   <= 8'd0;
            pkt_reg[2]   <= 8'd0;
            x_reg        <= 16'sd0;
            y_reg        <= 16'sd0;
            latch_reg    <= 8'd0;
        end
        else if (step)
        begin
            byte_idx_reg <= byte_idx_next;
            x_reg        <= dec.x_pos;
            y_reg        <= dec.y_pos;
            latch_reg    <= dec.status;
            if ((item.op == OP_RX_BYTE) && !last_byte)
            begin
                pkt_reg[byte_idx_reg] <= item.rx_byte;
            end
        end
    end

endmodule

// ----- hdl/pmf_status_fifo.sv -----
module pmf_status_fifo
    import pmf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  pmf_fifo_cmd_t cmd,
    output pmf_fifo_rsp_t rsp
);

    logic [7:0]       mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       head_reg;
    logic             full;
    logic             empty;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = cmd.push && !full;
    assign do_pop  = cmd.pop && !empty;

    assign wr_ptr_next = !do_push ? wr_ptr_reg :
                         (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = !do_pop ? rd_ptr_reg :
                         (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign rsp.dropped = cmd.push && full;
    assign rsp.popped  = do_pop;
    assign rsp.rdata   = do_pop ? head_reg : 8'd0;
    assign rsp.count   = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The head register always holds the word at the next read pointer, so a pop
    // needs no read in its own cycle. A word written to that slot now is bypassed.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= cmd.wdata;
        end
        if (do_push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= cmd.wdata;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("status FIFO count above depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(FIFO_DEPTH)) || (count_reg == '0)
        || (wr_ptr_reg != rd_ptr_reg))
        else $error("status FIFO pointers meet while partly filled");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("status FIFO count missed a push");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.dropped |-> (cmd.push && full && !do_push))
        else $error("status byte dropped with room left");

endmodule
